FILE: sv/facache_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facache_pkg
// Shared widths and codes for the fully associative FIFO-replacement cache.
// ----------------------------------------------------------------------------
package facache_pkg;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [DATA_W-1:0] READ_MISS_DATA = '1;

endpackage

FILE: sv/fully_associative_fifo_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_associative_fifo_cache_unit
// Fully associative word cache with round-robin line replacement.
// ----------------------------------------------------------------------------
// Each transfer is one read or write of a word address. The address is split
// into tag and word offset in the DIV and REM states: a multiplication by the
// reciprocal of WORDS_PER_LINE gives the tag, then a multiply-subtract gives
// the offset. The tag store is then scanned one line per cycle through a single
// comparator, stopping at the first valid match. A read hit passes through the
// RDWAIT state for the data memory read; a write miss fills the victim line
// word by word through the single data memory write port. The input is not
// ready while an access is in progress, and a finished result waits in the
// output register while the next transfer is taken. Reads that miss return -1
// and allocate nothing; writes report 0 as read data.
// ----------------------------------------------------------------------------
module fully_associative_fifo_cache_unit #(
  parameter int LINES          = 16,
  parameter int WORDS_PER_LINE = 8,
  parameter int ADDR_BITS      = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [facache_pkg::IN_TDATA_W-1:0]  in_tdata,   // address[31:0], write_data[63:32]
  input  logic                                in_tuser,   // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [facache_pkg::OUT_TDATA_W-1:0] out_tdata,  // read_data[31:0]
  output logic                                out_tuser   // hit
);

  import facache_pkg::*;

  localparam int LINE_W = $clog2(LINES);
  localparam int OFF_W  = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int TAG_W  = ADDR_BITS - ($clog2(WORDS_PER_LINE + 1) - 1);
  localparam int MEM_D  = LINES * WORDS_PER_LINE;
  localparam int MEM_AW = $clog2(MEM_D);
  localparam int RCP_SH = ADDR_BITS + $clog2(WORDS_PER_LINE);
  localparam int PROD_W = 2 * ADDR_BITS + 1;
  localparam logic [ADDR_BITS:0] RCP_M =
    (ADDR_BITS+1)'(((64'd1 << RCP_SH) + 64'(WORDS_PER_LINE) - 64'd1) / 64'(WORDS_PER_LINE));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;
  localparam logic [2:0] ST_REM    = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic                 func_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [OFF_W-1:0]     rem_r;
  logic [DATA_W-1:0]    wdata_r;
  logic [TAG_W-1:0]     tag_r;

  logic [LINE_W-1:0]    scan_idx_r;
  logic                 issue_done_r;
  logic                 cmp_en_r;
  logic [LINE_W-1:0]    cmp_idx_r;
  logic [TAG_W-1:0]     tag_q_r;
  logic [LINES-1:0]     valid_r;
  logic [LINE_W-1:0]    ptr_r;
  logic [OFF_W-1:0]     fill_cnt_r;

  logic [DATA_W-1:0]    res_data_r;
  logic                 res_hit_r;
  logic                 out_tvalid_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_hit_r;

  logic [TAG_W-1:0]     tag_mem [LINES];
  logic [DATA_W-1:0]    data_mem [MEM_D];
  logic [DATA_W-1:0]    rd_q_r;

  logic [PROD_W-1:0]    quot_prod;
  logic [OFF_W-1:0]     rem_calc;
  logic                 match;
  logic                 scan_last;
  logic                 in_xfer;
  logic                 out_load;
  logic                 dm_we;
  logic [MEM_AW-1:0]    dm_waddr;
  logic [MEM_AW-1:0]    dm_raddr;
  logic [DATA_W-1:0]    dm_wdata;
  logic                 tag_we;
  logic                 fill_last;

  function automatic logic [MEM_AW-1:0] line_base(input logic [LINE_W-1:0] line);
    line_base = MEM_AW'(line) * MEM_AW'(WORDS_PER_LINE);
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  assign quot_prod = PROD_W'(addr_r) * PROD_W'(RCP_M);
  assign rem_calc  = addr_r[OFF_W-1:0] - OFF_W'(tag_r) * OFF_W'(WORDS_PER_LINE);

  assign match     = cmp_en_r && valid_r[cmp_idx_r] && (tag_q_r == tag_r);
  assign scan_last = cmp_en_r && (cmp_idx_r == LINE_W'(LINES - 1));
  assign fill_last = (fill_cnt_r == OFF_W'(WORDS_PER_LINE - 1));

  assign tag_we   = (state_r == ST_SEARCH) && scan_last && !match && (func_r == FUNC_WRITE);
  assign dm_we    = ((state_r == ST_SEARCH) && match && (func_r == FUNC_WRITE)) ||
                    (state_r == ST_FILL);
  assign dm_raddr = line_base(cmp_idx_r) + MEM_AW'(rem_r);
  assign dm_waddr = (state_r == ST_FILL) ? line_base(ptr_r) + MEM_AW'(fill_cnt_r) : dm_raddr;
  assign dm_wdata = ((state_r == ST_FILL) && (fill_cnt_r != rem_r)) ? '0 : wdata_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_DIV;
      end
      ST_DIV: state_nxt = ST_REM;
      ST_REM: state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (match) begin
          state_nxt = (func_r == FUNC_WRITE) ? ST_OUT : ST_RDWAIT;
        end else if (scan_last) begin
          state_nxt = (func_r == FUNC_WRITE) ? ST_FILL : ST_OUT;
        end
      end
      ST_RDWAIT: state_nxt = ST_OUT;
      ST_FILL: begin
        if (fill_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      ptr_r        <= '0;
      cmp_en_r     <= 1'b0;
      issue_done_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      cmp_en_r <= (state_r == ST_SEARCH) && !issue_done_r && !match && !scan_last;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            func_r  <= in_tuser;
            addr_r  <= in_tdata[ADDR_BITS-1:0];
            wdata_r <= in_tdata[ADDR_W +: DATA_W];
          end
        end
        ST_DIV: begin
          tag_r <= quot_prod[RCP_SH +: TAG_W];
        end
        ST_REM: begin
          rem_r        <= rem_calc;
          scan_idx_r   <= '0;
          issue_done_r <= 1'b0;
        end
        ST_SEARCH: begin
          cmp_idx_r <= scan_idx_r;
          if (!issue_done_r) begin
            if (scan_idx_r == LINE_W'(LINES - 1)) begin
              issue_done_r <= 1'b1;
            end else begin
              scan_idx_r <= scan_idx_r + 1'b1;
            end
          end
          if (match) begin
            res_hit_r  <= 1'b1;
            res_data_r <= '0;
          end else if (scan_last) begin
            res_hit_r  <= 1'b0;
            res_data_r <= (func_r == FUNC_WRITE) ? '0 : READ_MISS_DATA;
            fill_cnt_r <= '0;
            if (func_r == FUNC_WRITE) valid_r[ptr_r] <= 1'b1;
          end
        end
        ST_RDWAIT: begin
          res_data_r <= rd_q_r;
        end
        ST_FILL: begin
          fill_cnt_r <= fill_cnt_r + 1'b1;
          if (fill_last) begin
            ptr_r <= (ptr_r == LINE_W'(LINES - 1)) ? '0 : ptr_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_r <= res_data_r;
            out_hit_r  <= res_hit_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tag_q_r <= tag_mem[scan_idx_r];
    if (tag_we) tag_mem[ptr_r] <= tag_r;
  end

  always_ff @(posedge clk) begin
    rd_q_r <= data_mem[dm_raddr];
    if (dm_we) data_mem[dm_waddr] <= dm_wdata;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

FILE: dv/fully_associative_fifo_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_associative_fifo_cache_unit_tb
// Self-checking bench for the fully associative round-robin word cache.
// ----------------------------------------------------------------------------
// A queue of read and write accesses, filled at time zero, feeds a driver. The
// accesses are a directed opening and then random accesses over a small,
// slowly changing pool of tags, so that hits, write misses and line evictions
// all occur. Every accepted access runs through a cache model in the bench,
// and the model's answer is compared with each result transfer. Both sides
// stall in random bursts, and the run ends with a stretch of no stalls.
// ----------------------------------------------------------------------------
module fully_associative_fifo_cache_unit_tb;
  import facache_pkg::*;

  localparam int LINES     = 16;
  localparam int WORDS     = 8;
  localparam int OFF_W     = 3;
  localparam int TAG_W     = ADDR_W - OFF_W;
  localparam int N_RANDOM  = 680;
  localparam int POOL_SIZE = 24;
  localparam int CALM_TAIL = 100;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    bit                drain;
  } access_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              hit;
  } access_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  access_t        access_q[$];
  access_result_t result_q[$];

  logic              line_valid[LINES] = '{default: 1'b0};
  logic [TAG_W-1:0]  line_tag[LINES];
  logic [DATA_W-1:0] line_data[LINES][WORDS];
  logic [3:0]        fill_ptr = '0;

  int n_total     = 0;
  int issued_cnt  = 0;
  int accept_cnt  = 0;
  int rx_cnt      = 0;
  int err_cnt     = 0;
  int in_gap      = 0;
  int out_stall   = 0;

  fully_associative_fifo_cache_unit #(
    .LINES         (LINES),
    .WORDS_PER_LINE(WORDS),
    .ADDR_BITS     (ADDR_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic access_result_t cache_access(logic func, logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] wdata);
    access_result_t   r;
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] off;
    int               line;
    int               i;
    tag         = addr[ADDR_W-1:OFF_W];
    off         = addr[OFF_W-1:0];
    line        = -1;
    for (i = 0; i < LINES; i++) begin
      if (line < 0 && line_valid[i] && line_tag[i] == tag) line = i;
    end
    r.hit       = (line >= 0);
    r.read_data = '0;
    if (func == FUNC_READ) begin
      r.read_data = r.hit ? line_data[line][off] : READ_MISS_DATA;
    end else if (r.hit) begin
      line_data[line][off] = wdata;
    end else begin
      for (i = 0; i < WORDS; i++) line_data[fill_ptr][i] = '0;
      line_data[fill_ptr][off] = wdata;
      line_tag[fill_ptr]       = tag;
      line_valid[fill_ptr]     = 1'b1;
      fill_ptr                 = fill_ptr + 1'b1;
    end
    return r;
  endfunction

  task automatic add_access(logic func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                            bit drain = 1'b0);
    access_t a;
    a.func  = func;
    a.addr  = addr;
    a.wdata = wdata;
    a.drain = drain;
    access_q.push_back(a);
  endtask

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch at result %0d: %s got %h want %h", rx_cnt, field, got, want);
    err_cnt++;
  endtask

  // Driver: present accesses at the falling edge, hold until transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || accept_cnt == issued_cnt) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (access_q.size() == 0 || (access_q[0].drain && result_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else if (issued_cnt < n_total - CALM_TAIL && (issued_cnt / 50) % 3 != 0
                   && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {access_q[0].wdata, access_q[0].addr};
        in_tuser  <= access_q[0].func;
        void'(access_q.pop_front());
        issued_cnt++;
      end
    end
  end

  // Predict on every accepted input transfer.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      result_q.push_back(cache_access(in_tuser, in_tdata[ADDR_W-1:0],
                                      in_tdata[ADDR_W +: DATA_W]));
      accept_cnt++;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (rx_cnt < n_total - CALM_TAIL && (rx_cnt / 64) % 3 != 1
                 && $urandom_range(0, 6) == 0) begin
      out_stall = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result, read_data", out_tdata, '0);
      end else begin
        want = result_q.pop_front();
        if (out_tdata !== want.read_data) report_mismatch("read_data", out_tdata, want.read_data);
        if (out_tuser !== want.hit) report_mismatch("hit", {31'b0, out_tuser}, {31'b0, want.hit});
      end
      rx_cnt++;
    end
  end

  initial begin
    logic [TAG_W-1:0]  tag_pool[POOL_SIZE];
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] wdata;
    logic              func;
    int                k;
    int                idx;

    // directed opening
    add_access(FUNC_READ,  32'h0000_0000, 32'h0);
    add_access(FUNC_WRITE, 32'h0000_0000, 32'h8000_0000);
    add_access(FUNC_READ,  32'h0000_0000, 32'h0);
    add_access(FUNC_READ,  32'h0000_0001, 32'hFFFF_FFFF);
    add_access(FUNC_WRITE, 32'h0000_0007, 32'h7FFF_FFFF);
    add_access(FUNC_READ,  32'h0000_0007, 32'h0);
    add_access(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_access(FUNC_READ,  32'hFFFF_FFF8, 32'h0);
    add_access(FUNC_READ,  32'hFFFF_FFFF, 32'h0);
    for (k = 1; k <= 15; k++) add_access(FUNC_WRITE, (k << OFF_W) | (k % WORDS), k * 32'h1111);
    add_access(FUNC_READ,  32'h0000_0000, 32'h0);

    for (k = 0; k < POOL_SIZE; k++) tag_pool[k] = TAG_W'($urandom);
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 100 == 99) tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom);
      idx   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POOL_SIZE - 1)
                                           : $urandom_range(0, 11);
      tag   = ($urandom_range(0, 19) == 0) ? TAG_W'($urandom) : tag_pool[idx];
      func  = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
      case ($urandom_range(0, 9))
        0:       wdata = 32'h8000_0000;
        1:       wdata = 32'h7FFF_FFFF;
        2:       wdata = 32'hFFFF_FFFF;
        3:       wdata = 32'h0;
        default: wdata = $urandom;
      endcase
      add_access(func, {tag, OFF_W'($urandom)}, wdata, k == 0 || k == 350);
    end
    n_total = access_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accept_cnt < n_total || result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
